FILE: hw/rtl/photoelastic_four_step_pixel_core_assert.svh
// Assertion macros shared by the pixel core RTL.
// Each use expects clk and arst_n in scope.
`ifndef PHOTOELASTIC_FOUR_STEP_PIXEL_CORE_ASSERT_SVH
`define PHOTOELASTIC_FOUR_STEP_PIXEL_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PE4S_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PE4S_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PE4S_ASSERT_NOW(lbl, ante, cons, msg)
`define PE4S_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/pe4s_pkg.sv
package pe4s_pkg;

	localparam int DEF_PIXEL_BITS      = 8;
	localparam int DEF_ANGLE_FRAC_BITS = 16;

	localparam int SUM_W       = 10;
	localparam int ND_W        = 12;
	localparam int Q_W         = 11;
	localparam int RR_W        = 24;
	localparam int RR_SHIFT    = 20;
	localparam int ROOT_IN_W   = RR_W + RR_SHIFT;
	localparam int ROOT_W      = ROOT_IN_W / 2;
	localparam int ISO_W       = 44;
	localparam int RET_W       = 54;
	localparam int Z_W         = 34;
	localparam int CORDIC_ITERS = 31;
	localparam int CORDIC_SCALE = 28;
	localparam int Q_SCALE      = 10;
	localparam int ANGLE_AW     = 42;

	localparam logic [31:0] ATAN_TURN32 [0:CORDIC_ITERS-1] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
		32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
		32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1
	};

	typedef enum logic [1:0] {
		CFG_MASK_ENABLE = 2'd0,
		CFG_MASK_LOW    = 2'd1,
		CFG_MASK_HIGH   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] red_a;
		logic [7:0] green_a;
		logic [7:0] blue_a;
		logic [7:0] red_b;
		logic [7:0] green_b;
		logic [7:0] blue_b;
		logic [7:0] red_c;
		logic [7:0] green_c;
		logic [7:0] blue_c;
		logic [7:0] red_d;
		logic [7:0] green_d;
		logic [7:0] blue_d;
	} in_beat_t;

	typedef struct packed {
		logic [6:0]  isoclinic_deg;
		logic [7:0]  retardation_code;
		logic [15:0] retardation_fine;
		logic        degenerate;
	} out_beat_t;

	typedef struct packed {
		logic signed [ND_W-1:0] n;
		logic signed [ND_W-1:0] d;
		logic signed [Q_W-1:0]  q;
	} nd_t;

	typedef struct packed {
		nd_t             nd;
		logic [RR_W-1:0] rr;
	} front_t;

	typedef struct packed {
		logic d_zero;
		logic n_zero;
	} iso_side_t;

	typedef struct packed {
		logic rr_zero;
		logic q_zero;
		logic d_neg;
		logic q_pos;
	} ret_side_t;

endpackage

FILE: hw/rtl/pe4s_front.sv
module pe4s_front #(
	parameter int PIXEL_BITS = pe4s_pkg::DEF_PIXEL_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid,
	input  pe4s_pkg::in_beat_t pixel,
	output logic               res_valid,
	output pe4s_pkg::front_t   res
);

	localparam logic [7:0] PMASK = (PIXEL_BITS >= 8) ? 8'hFF : 8'((1 << PIXEL_BITS) - 1);
	localparam int SW = pe4s_pkg::SUM_W;
	localparam int NW = pe4s_pkg::ND_W;
	localparam int QW = pe4s_pkg::Q_W;

	logic [SW-1:0] s0, s1, s2, s3;
	logic signed [NW-1:0] n, d;
	logic signed [QW-1:0] q;
	logic signed [NW-1:0] n_s1, d_s1;
	logic signed [QW-1:0] q_s1;
	logic v_s1, v_s2;
	logic signed [2*NW-1:0] nn, dd;
	pe4s_pkg::front_t f_s2;

	always_comb begin
		s0 = SW'(pixel.red_a & PMASK) + SW'(pixel.green_a & PMASK) + SW'(pixel.blue_a & PMASK);
		s1 = SW'(pixel.red_b & PMASK) + SW'(pixel.green_b & PMASK) + SW'(pixel.blue_b & PMASK);
		s2 = SW'(pixel.red_c & PMASK) + SW'(pixel.green_c & PMASK) + SW'(pixel.blue_c & PMASK);
		s3 = SW'(pixel.red_d & PMASK) + SW'(pixel.green_d & PMASK) + SW'(pixel.blue_d & PMASK);
		n = $signed({2'b00, s0}) + $signed({2'b00, s1}) - $signed({1'b0, s3, 1'b0});
		d = $signed({1'b0, s2, 1'b0}) - $signed({2'b00, s0}) - $signed({2'b00, s1});
		q = $signed({1'b0, s1}) - $signed({1'b0, s0});
	end

	assign nn = n_s1 * n_s1;
	assign dd = d_s1 * d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1 <= n;
			d_s1 <= d;
			q_s1 <= q;
			f_s2.nd.n <= n_s1;
			f_s2.nd.d <= d_s1;
			f_s2.nd.q <= q_s1;
			f_s2.rr <= pe4s_pkg::RR_W'($unsigned(nn)) + pe4s_pkg::RR_W'($unsigned(dd));
		end
	end

	assign res_valid = v_s2;
	assign res = f_s2;

endmodule

FILE: hw/rtl/pe4s_isqrt.sv
module pe4s_isqrt #(
	parameter int VW = pe4s_pkg::ROOT_IN_W,
	parameter int SW = $bits(pe4s_pkg::nd_t)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid,
	input  logic [VW-1:0]     radicand,
	input  logic [SW-1:0]     side,
	output logic              res_valid,
	output logic [VW/2-1:0]   root,
	output logic [SW-1:0]     res_side
);

	localparam int STEPS = VW / 2;

	logic [VW-1:0] v_s [0:STEPS];
	logic [VW-1:0] r_s [0:STEPS];
	logic [SW-1:0] sd_s [0:STEPS];
	logic          vl_s [0:STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vl_s[0] <= 1'b0;
		end else if (en) begin
			vl_s[0] <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s[0] <= radicand;
			r_s[0] <= '0;
			sd_s[0] <= side;
		end
	end

	for (genvar j = 0; j < STEPS; j++) begin : g_step
		localparam logic [VW:0] BIT = (VW + 1)'(1) << (VW - 2 - 2 * j);
		logic [VW:0] t;

		assign t = {1'b0, r_s[j]} + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vl_s[j+1] <= 1'b0;
			end else if (en) begin
				vl_s[j+1] <= vl_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sd_s[j+1] <= sd_s[j];
				if ({1'b0, v_s[j]} >= t) begin
					v_s[j+1] <= VW'({1'b0, v_s[j]} - t);
					r_s[j+1] <= VW'(({1'b0, r_s[j]} >> 1) + BIT);
				end else begin
					v_s[j+1] <= v_s[j];
					r_s[j+1] <= r_s[j] >> 1;
				end
			end
		end
	end

	assign res_valid = vl_s[STEPS];
	assign root = r_s[STEPS][VW/2-1:0];
	assign res_side = sd_s[STEPS];

endmodule

FILE: hw/rtl/pe4s_cordic.sv
module pe4s_cordic #(
	parameter int W     = pe4s_pkg::RET_W,
	parameter int SW    = $bits(pe4s_pkg::ret_side_t),
	parameter int ITERS = pe4s_pkg::CORDIC_ITERS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            valid,
	input  logic signed [W-1:0]             x,
	input  logic signed [W-1:0]             y,
	input  logic [SW-1:0]                   side,
	output logic                            res_valid,
	output logic signed [pe4s_pkg::Z_W-1:0] angle,
	output logic [SW-1:0]                   res_side
);

	localparam int ZW = pe4s_pkg::Z_W;

	logic signed [W-1:0]  x_s [0:ITERS];
	logic signed [W-1:0]  y_s [0:ITERS];
	logic signed [ZW-1:0] z_s [0:ITERS];
	logic [SW-1:0]        sd_s [0:ITERS];
	logic                 v_s [0:ITERS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= x;
			y_s[0] <= y;
			z_s[0] <= '0;
			sd_s[0] <= side;
		end
	end

	for (genvar i = 0; i < ITERS; i++) begin : g_iter
		localparam logic signed [ZW-1:0] AT = ZW'(pe4s_pkg::ATAN_TURN32[i]);
		logic signed [W-1:0] dx, dy;

		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		// a vector already on the axis stays put
		always_ff @(posedge clk) begin
			if (en) begin
				sd_s[i+1] <= sd_s[i];
				if (y_s[i] == '0) begin
					x_s[i+1] <= x_s[i];
					y_s[i+1] <= y_s[i];
					z_s[i+1] <= z_s[i];
				end else if (!y_s[i][W-1]) begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + AT;
				end else begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - AT;
				end
			end
		end
	end

	assign res_valid = v_s[ITERS];
	assign angle = z_s[ITERS];
	assign res_side = sd_s[ITERS];

endmodule

FILE: hw/rtl/pe4s_post.sv
module pe4s_post #(
	parameter int ANGLE_FRAC_BITS = pe4s_pkg::DEF_ANGLE_FRAC_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            valid,
	input  logic signed [pe4s_pkg::Z_W-1:0] iso_z,
	input  pe4s_pkg::iso_side_t             iso_side,
	input  logic signed [pe4s_pkg::Z_W-1:0] ret_z,
	input  pe4s_pkg::ret_side_t             ret_side,
	input  logic                            mask_enable,
	input  logic [6:0]                      mask_low_deg,
	input  logic [6:0]                      mask_high_deg,
	output logic                            res_valid,
	output pe4s_pkg::out_beat_t             res
);

	localparam int AW = pe4s_pkg::ANGLE_AW;
	localparam int ZW = pe4s_pkg::Z_W;
	localparam logic signed [AW-1:0] ONE_DEG = AW'(1) << ANGLE_FRAC_BITS;
	localparam logic signed [AW-1:0] DEG45   = AW'(45) * ONE_DEG;
	localparam logic signed [AW-1:0] DEG90   = AW'(90) * ONE_DEG;
	localparam logic signed [ZW:0] QTURN   = (ZW + 1)'(1) << 30;
	localparam logic signed [ZW:0] HTURN   = (ZW + 1)'(1) << 31;

	logic signed [AW-1:0] iso_mul_s1;
	logic [31:0] ret_s1;
	logic d_zero_s1, n_zero_s1, degen_s1, v_s1, v_s2;
	logic signed [ZW:0] rsum;
	logic [31:0] ret_nx;
	logic signed [AW-1:0] a, lo_b, hi_b;
	logic [40:0] prod;
	pe4s_pkg::out_beat_t o_s2;

	// retardation as binary angle, 2^32 per fringe
	always_comb begin
		if (!ret_side.d_neg == ret_side.q_pos) begin
			rsum = QTURN + (ZW + 1)'(ret_z);
		end else begin
			rsum = QTURN - (ZW + 1)'(ret_z);
		end
		if (ret_side.rr_zero) begin
			ret_nx = 32'(QTURN);
		end else if (ret_side.q_zero) begin
			ret_nx = ret_side.d_neg ? 32'd0 : 32'(HTURN);
		end else if (rsum < 0) begin
			ret_nx = 32'd0;
		end else if (rsum > HTURN) begin
			ret_nx = 32'(HTURN);
		end else begin
			ret_nx = 32'(rsum);
		end
	end

	// fold the isoclinic angle into 0..90 and apply the window
	always_comb begin
		lo_b = AW'(mask_low_deg) << ANGLE_FRAC_BITS;
		hi_b = AW'(mask_high_deg) << ANGLE_FRAC_BITS;
		if (d_zero_s1) begin
			a = n_zero_s1 ? '0 : DEG45;
		end else begin
			a = iso_mul_s1 >>> (32 - ANGLE_FRAC_BITS);
			if (a < 0) begin
				a = a + DEG90;
			end
			if (a < 0) begin
				a = '0;
			end
			if (a > DEG90 - 1) begin
				a = DEG90 - 1;
			end
		end
		if (mask_enable && (a > lo_b) && (a < hi_b)) begin
			a = '0;
		end
		prod = 41'(ret_s1) * 41'(500);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			iso_mul_s1 <= AW'(iso_z) * AW'(180);
			ret_s1 <= ret_nx;
			d_zero_s1 <= iso_side.d_zero;
			n_zero_s1 <= iso_side.n_zero;
			degen_s1 <= iso_side.d_zero | ret_side.q_zero;
			o_s2.isoclinic_deg <= a[ANGLE_FRAC_BITS+6:ANGLE_FRAC_BITS];
			o_s2.retardation_code <= prod[39:32];
			o_s2.retardation_fine <= ret_s1[31:16];
			o_s2.degenerate <= degen_s1;
		end
	end

	assign res_valid = v_s2;
	assign res = o_s2;

endmodule

FILE: hw/rtl/photoelastic_four_step_pixel_core.sv
// A pixel beat passes the front, square-root, arctangent and post stages, then the output register.
// Throughput: one pixel per cycle while the skid register is empty; the 22-step square-root
// pipeline and the two 31-stage arctangent pipelines advance together, one stage per cycle.
// A result that waits on out_ready is held in the output register, and one more beat
// lands in a skid register; the input stalls only while that skid register is full.
// Reset (arst_n low) clears all valid bits and loads mask_enable=0, low=0, high=90.
`include "photoelastic_four_step_pixel_core_assert.svh"

module photoelastic_four_step_pixel_core #(
	parameter int PIXEL_BITS      = pe4s_pkg::DEF_PIXEL_BITS,
	parameter int ANGLE_FRAC_BITS = pe4s_pkg::DEF_ANGLE_FRAC_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pe4s_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output pe4s_pkg::out_beat_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [6:0]          cfg_data
);

	localparam int NW = pe4s_pkg::ND_W;
	localparam int QW = pe4s_pkg::Q_W;
	localparam int IW = pe4s_pkg::ISO_W;
	localparam int RW = pe4s_pkg::RET_W;
	localparam int ZW = pe4s_pkg::Z_W;

	// configuration registers
	logic       mask_enable_q;
	logic [6:0] mask_low_q, mask_high_q;

	// pipeline advance: the whole datapath moves as one while the skid register is free
	logic en;

	logic             front_valid;
	pe4s_pkg::front_t front;

	logic                          root_valid;
	logic [pe4s_pkg::ROOT_W-1:0]   root;
	logic [$bits(pe4s_pkg::nd_t)-1:0] root_side;
	pe4s_pkg::nd_t                 nd;

	logic signed [NW-1:0] d_abs, y_nd;
	logic signed [QW-1:0] q_abs;
	logic signed [IW-1:0] iso_x, iso_y;
	logic signed [RW-1:0] ret_x, ret_y;
	pe4s_pkg::iso_side_t  iso_side_in, iso_side_out;
	pe4s_pkg::ret_side_t  ret_side_in, ret_side_out;
	logic                 iso_valid, ret_valid;
	logic signed [ZW-1:0] iso_z, ret_z;

	logic                tail_valid;
	pe4s_pkg::out_beat_t tail;

	// output register and skid register
	logic                out_v_q, skid_v_q;
	pe4s_pkg::out_beat_t out_q, skid_q;
	logic                push, pop;

	assign en = !skid_v_q;
	assign in_ready = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_enable_q <= 1'b0;
			mask_low_q <= 7'd0;
			mask_high_q <= 7'd90;
		end else if (cfg_valid) begin
			case (pe4s_pkg::cfg_reg_t'(cfg_index))
				pe4s_pkg::CFG_MASK_ENABLE: mask_enable_q <= cfg_data[0];
				pe4s_pkg::CFG_MASK_LOW:    mask_low_q <= cfg_data;
				pe4s_pkg::CFG_MASK_HIGH:   mask_high_q <= cfg_data;
				default: begin
					// drop writes to unmapped indexes
				end
			endcase
		end
	end

	// channel sums, N, D, Q and N^2 + D^2
	pe4s_front #(
		.PIXEL_BITS(PIXEL_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.valid(in_valid),
		.pixel(in_data),
		.res_valid(front_valid),
		.res(front)
	);

	// sqrt((N^2 + D^2) * 2^20), one result bit per stage
	pe4s_isqrt #(
		.VW(pe4s_pkg::ROOT_IN_W),
		.SW($bits(pe4s_pkg::nd_t))
	) u_isqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.valid(front_valid),
		.radicand({front.rr, pe4s_pkg::RR_SHIFT'(0)}),
		.side(front.nd),
		.res_valid(root_valid),
		.root(root),
		.res_side(root_side)
	);

	// build both vectoring inputs from the delayed N, D, Q
	always_comb begin
		nd = pe4s_pkg::nd_t'(root_side);
		d_abs = nd.d[NW-1] ? -nd.d : nd.d;
		y_nd = (nd.d > 0) ? nd.n : -nd.n;
		q_abs = nd.q[QW-1] ? -nd.q : nd.q;
		iso_x = IW'(d_abs) <<< pe4s_pkg::CORDIC_SCALE;
		iso_y = IW'(y_nd) <<< pe4s_pkg::CORDIC_SCALE;
		ret_x = RW'(q_abs) <<< (pe4s_pkg::CORDIC_SCALE + pe4s_pkg::Q_SCALE);
		ret_y = $signed(RW'(root)) <<< pe4s_pkg::CORDIC_SCALE;
		iso_side_in.d_zero = (nd.d == '0);
		iso_side_in.n_zero = (nd.n == '0);
		ret_side_in.rr_zero = (nd.n == '0) && (nd.d == '0);
		ret_side_in.q_zero = (nd.q == '0);
		ret_side_in.d_neg = nd.d[NW-1];
		ret_side_in.q_pos = !nd.q[QW-1] && (nd.q != '0);
	end

	// isoclinic: angle of (|D|, N if D > 0, else -N)
	pe4s_cordic #(
		.W(IW),
		.SW($bits(pe4s_pkg::iso_side_t)),
		.ITERS(pe4s_pkg::CORDIC_ITERS)
	) u_iso_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.valid(root_valid),
		.x(iso_x),
		.y(iso_y),
		.side(iso_side_in),
		.res_valid(iso_valid),
		.angle(iso_z),
		.res_side(iso_side_out)
	);

	// retardation: angle of (|Q|, R), same length so both lanes stay aligned
	pe4s_cordic #(
		.W(RW),
		.SW($bits(pe4s_pkg::ret_side_t)),
		.ITERS(pe4s_pkg::CORDIC_ITERS)
	) u_ret_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.valid(root_valid),
		.x(ret_x),
		.y(ret_y),
		.side(ret_side_in),
		.res_valid(ret_valid),
		.angle(ret_z),
		.res_side(ret_side_out)
	);

	// degrees, folding, masking, output scaling
	pe4s_post #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_post (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.valid(iso_valid & ret_valid),
		.iso_z(iso_z),
		.iso_side(iso_side_out),
		.ret_z(ret_z),
		.ret_side(ret_side_out),
		.mask_enable(mask_enable_q),
		.mask_low_deg(mask_low_q),
		.mask_high_deg(mask_high_q),
		.res_valid(tail_valid),
		.res(tail)
	);

	// a beat leaves the pipeline tail on every advance; park it in the skid
	// register when the output register is still waiting
	assign push = en && tail_valid;
	assign pop = out_v_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else if (!push) begin
				out_v_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_v_q) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= tail;
			end
		end else if (push) begin
			if (!out_v_q) begin
				out_q <= tail;
			end else begin
				skid_q <= tail;
			end
		end
	end

	assign out_valid = out_v_q;
	assign out_data = out_q;

	`PE4S_ASSERT_NOW(a_skid_behind_out, skid_v_q, out_v_q, "skid beat without output beat")
	`PE4S_ASSERT_NOW(a_lanes_aligned, 1'b1, iso_valid == ret_valid, "cordic lanes out of step")
	`PE4S_ASSERT_NEXT(a_skid_fill, push && out_v_q && !out_ready, skid_v_q, "stalled beat lost")
	`PE4S_ASSERT_NOW(a_fine_range, out_v_q, out_q.retardation_fine <= 16'd32768, "fine out of range")
	`PE4S_ASSERT_NOW(a_iso_range, out_v_q, out_q.isoclinic_deg <= 7'd89, "isoclinic out of range")

endmodule
